// ===== rtl/ddag_pkg.sv =====
// Shared types, constants and codes of the grid ray caster.
package ddag_pkg;

  localparam int MAP_SIZE_DEF = 32;
  localparam int DIV_NW = 33;
  localparam int DIV_DW = 34;
  localparam int SIDE_W = 60;
  localparam int DELTA_W = 51;
  localparam logic [DELTA_W-1:0] DELTA_SAT = DELTA_W'(1) << 50;
  localparam logic [23:0] DIST_MAX = 24'hFFFFFF;
  localparam logic [16:0] Q_ONE = 17'h10000;

  localparam logic [20:0] POS_X_RST = 21'd786432;
  localparam logic [20:0] POS_Y_RST = 21'd786432;
  localparam logic [17:0] DIR_X_RST = 18'd65536;
  localparam logic [17:0] DIR_Y_RST = 18'd0;
  localparam logic [17:0] PLANE_X_RST = 18'd0;
  localparam logic [17:0] PLANE_Y_RST = 18'd43254;
  localparam logic [12:0] SCR_W_RST = 13'd640;
  localparam logic [12:0] SCR_H_RST = 13'd480;

  typedef enum logic [2:0] {
    CFG_POS_X, CFG_POS_Y, CFG_DIR_X, CFG_DIR_Y,
    CFG_PLANE_X, CFG_PLANE_Y, CFG_SCR_W, CFG_SCR_H
  } cfg_idx_t;

  typedef struct packed {
    logic        action;
    logic [11:0] column;
    logic [4:0]  cell_x;
    logic [4:0]  cell_y;
    logic [7:0]  cell_code;
  } in_t;

  typedef struct packed {
    logic        hit_side;
    logic [4:0]  hit_x;
    logic [4:0]  hit_y;
    logic [7:0]  wall_code;
    logic [23:0] wall_distance;
    logic [12:0] line_height;
    logic [11:0] line_bottom;
    logic [12:0] line_top;
    logic        escaped;
  } out_t;

  typedef struct packed {
    logic [20:0]        pos_x;
    logic [20:0]        pos_y;
    logic signed [17:0] dir_x;
    logic signed [17:0] dir_y;
    logic signed [17:0] plane_x;
    logic signed [17:0] plane_y;
    logic [12:0]        screen_width;
    logic [12:0]        screen_height;
  } cfg_t;

  typedef struct packed {
    logic        cast;
    logic        wr_ok;
    logic [4:0]  cx;
    logic [4:0]  cy;
    logic [7:0]  code;
    logic [11:0] column;
  } cmd_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_CAM, ST_MUL, ST_RAY, ST_DXS, ST_DXW, ST_DYW,
    ST_SIDE, ST_WALK, ST_TEST, ST_FIN, ST_LHW, ST_LINE, ST_EMIT
  } back_st_t;

endpackage

// ===== rtl/ddag_ram.sv =====
// Generic simple dual-port RAM with registered read.
module ddag_ram #(
  parameter int W = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata_r
);
  logic [W-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    rdata_r <= mem_r[raddr];
  end
endmodule

// ===== rtl/ddag_fifo.sv =====
// Small register FIFO.
module ddag_fifo #(
  parameter int W = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (do_pop) rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      if (do_push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end
endmodule

// ===== rtl/ddag_front.sv =====
// Front end: classifies requests and queues them for the back end.
module ddag_front #(
  parameter int MAP_SIZE = ddag_pkg::MAP_SIZE_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ddag_pkg::in_t  din,
  output logic           full,
  input  logic           pop,
  output ddag_pkg::cmd_t cmd,
  output logic           empty
);
  import ddag_pkg::*;

  cmd_t cls;

  always_comb begin
    cls.cast   = din.action;
    cls.wr_ok  = !din.action && (9'(din.cell_x) < 9'(MAP_SIZE))
                 && (9'(din.cell_y) < 9'(MAP_SIZE));
    cls.cx     = din.cell_x;
    cls.cy     = din.cell_y;
    cls.code   = din.cell_code;
    cls.column = din.column;
  end

  ddag_fifo #(.W($bits(cmd_t)), .DEPTH(2)) u_q (
    .clk(clk), .rst_n(rst_n), .push(push), .din(cls), .full(full),
    .pop(pop), .dout(cmd), .empty(empty)
  );
endmodule

// ===== rtl/ddag_div.sv =====
// Restoring divider, one quotient bit per cycle.
module ddag_div (
  input  logic               clk,
  input  logic               rst_n,
  input  ddag_pkg::div_req_t req,
  output ddag_pkg::div_rsp_t rsp
);
  import ddag_pkg::*;

  logic [DIV_NW-1:0] dvd_r;
  logic [DIV_DW-1:0] dvs_r;
  logic [DIV_DW-1:0] rem_r;
  logic [5:0]        cnt_r;
  logic              busy_r, done_r;
  logic [DIV_DW:0]   trial;
  logic              qbit;

  assign trial = {rem_r, dvd_r[DIV_NW-1]};
  assign qbit  = (trial >= {1'b0, dvs_r});
  assign rsp.done     = done_r;
  assign rsp.quotient = dvd_r;

  always_ff @(posedge clk) begin
    if (req.start && !busy_r) begin
      dvd_r <= req.dividend;
      dvs_r <= req.divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= qbit ? DIV_DW'(trial - {1'b0, dvs_r}) : DIV_DW'(trial);
      dvd_r <= {dvd_r[DIV_NW-2:0], qbit};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start && !busy_r) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == 6'(DIV_NW - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end
endmodule

// ===== rtl/ddag_back.sv =====
// Back end: map writes, ray setup, DDA walk and wall strip.
module ddag_back #(
  parameter int MAP_SIZE = ddag_pkg::MAP_SIZE_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  ddag_pkg::cfg_t cfg,
  input  ddag_pkg::cmd_t cmd,
  input  logic           cmd_empty,
  output logic           cmd_pop,
  output ddag_pkg::out_t res,
  output logic           res_push,
  input  logic           res_full,
  output logic           clearing
);
  import ddag_pkg::*;

  localparam int DEPTH = MAP_SIZE * MAP_SIZE;
  localparam int AW = $clog2(DEPTH);
  localparam int XW = ($clog2(MAP_SIZE) > 5) ? $clog2(MAP_SIZE) : 5;
  localparam int NSTEP = 2 * MAP_SIZE + 2;
  localparam int SCW = $clog2(NSTEP + 1);

  back_st_t state_r, state_nxt;
  div_req_t dreq;
  div_rsp_t drsp;

  logic [AW-1:0]        clr_r;
  logic signed [31:0]   cam_r;
  logic signed [49:0]   prodx_r, prody_r;
  logic signed [34:0]   rx_r, ry_r;
  logic [DELTA_W-1:0]   dx_r, dy_r;
  logic [SIDE_W-1:0]    sx_r, sy_r, dist_r;
  logic                 nx_r, ny_r, side_r, esc_r;
  logic [XW-1:0]        mx_r, my_r;
  logic [SCW-1:0]       steps_r;
  logic [7:0]           code_r;
  logic [12:0]          lh_r;
  out_t                 res_r;

  logic                 we;
  logic [AW-1:0]        waddr, raddr;
  logic [7:0]           wdata, rdata;
  logic [34:0]          arx, ary;
  logic [12:0]          w_eff, h;
  logic                 go_x, leave, outside;
  logic [XW-1:0]        nmx, nmy;
  logic [23:0]          dsat;
  logic [16:0]          fx, fy;
  logic [49:0]          px_prod, py_prod;
  logic [13:0]          top_sum;
  logic [11:0]          bot;

  assign h     = cfg.screen_height;
  assign w_eff = (cfg.screen_width == '0) ? 13'd1 : cfg.screen_width;
  assign arx   = rx_r[34] ? 35'(-rx_r) : rx_r;
  assign ary   = ry_r[34] ? 35'(-ry_r) : ry_r;
  assign outside = ({1'b0, XW'(cfg.pos_x[20:16])} >= (XW+1)'(MAP_SIZE))
                   || ({1'b0, XW'(cfg.pos_y[20:16])} >= (XW+1)'(MAP_SIZE));
  assign go_x  = sx_r < sy_r;
  assign leave = go_x ? (nx_r ? (mx_r == '0) : (mx_r == XW'(MAP_SIZE - 1)))
                      : (ny_r ? (my_r == '0) : (my_r == XW'(MAP_SIZE - 1)));
  assign nmx   = go_x ? (nx_r ? mx_r - 1'b1 : mx_r + 1'b1) : mx_r;
  assign nmy   = go_x ? my_r : (ny_r ? my_r - 1'b1 : my_r + 1'b1);
  assign dsat  = (dist_r > SIDE_W'(DIST_MAX)) ? DIST_MAX : dist_r[23:0];
  assign fx    = rx_r[34] ? {1'b0, cfg.pos_x[15:0]} : Q_ONE - {1'b0, cfg.pos_x[15:0]};
  assign fy    = ry_r[34] ? {1'b0, cfg.pos_y[15:0]} : Q_ONE - {1'b0, cfg.pos_y[15:0]};
  assign px_prod = 50'(fx) * 50'(dx_r[32:0]);
  assign py_prod = 50'(fy) * 50'(dy_r[32:0]);
  assign bot   = (h[12:1] >= lh_r[12:1]) ? h[12:1] - lh_r[12:1] : 12'd0;
  assign top_sum = {2'b00, bot} + {1'b0, lh_r};
  assign res   = res_r;
  assign clearing = (state_r == ST_CLEAR);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_r == AW'(DEPTH - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (!cmd_empty && cmd.cast) state_nxt = ST_CAM;
      ST_CAM:   if (drsp.done) state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_RAY;
      ST_RAY:   state_nxt = ST_DXS;
      ST_DXS:   state_nxt = ST_DXW;
      ST_DXW:   if (drsp.done) state_nxt = ST_DYW;
      ST_DYW:   if (drsp.done) state_nxt = ST_SIDE;
      ST_SIDE:  state_nxt = outside ? ST_FIN : ST_WALK;
      ST_WALK:  state_nxt = leave ? ST_FIN : ST_TEST;
      ST_TEST:  if (rdata != '0 || steps_r == SCW'(NSTEP)) state_nxt = ST_FIN;
                else state_nxt = ST_WALK;
      ST_FIN:   state_nxt = (dsat == '0) ? ST_LINE : ST_LHW;
      ST_LHW:   if (drsp.done) state_nxt = ST_LINE;
      ST_LINE:  state_nxt = ST_EMIT;
      ST_EMIT:  if (!res_full) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop  = 1'b0;
    res_push = 1'b0;
    we       = 1'b0;
    waddr    = AW'(cmd.cx) * AW'(MAP_SIZE) + AW'(cmd.cy);
    wdata    = cmd.code;
    raddr    = AW'(nmx) * AW'(MAP_SIZE) + AW'(nmy);
    dreq     = '0;
    unique case (state_r)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_r;
        wdata = '0;
      end
      ST_IDLE: begin
        cmd_pop = !cmd_empty;
        we      = !cmd_empty && !cmd.cast && cmd.wr_ok;
        dreq.start    = !cmd_empty && cmd.cast;
        dreq.dividend = DIV_NW'({cmd.column, 17'd0});
        dreq.divisor  = DIV_DW'(w_eff);
      end
      ST_DXS: begin
        dreq.start    = 1'b1;
        dreq.dividend = DIV_NW'(33'h1_0000_0000);
        dreq.divisor  = arx[DIV_DW-1:0];
      end
      ST_DXW: begin
        dreq.start    = drsp.done;
        dreq.dividend = DIV_NW'(33'h1_0000_0000);
        dreq.divisor  = ary[DIV_DW-1:0];
      end
      ST_FIN: begin
        dreq.start    = (dsat != '0);
        dreq.dividend = DIV_NW'({h, 16'd0});
        dreq.divisor  = DIV_DW'(dsat);
      end
      ST_EMIT: res_push = !res_full;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_r <= clr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_CAM: if (drsp.done) cam_r <= $signed({3'b000, drsp.quotient[28:0]}) - 32'sd65536;
      ST_MUL: begin
        prodx_r <= 50'(cfg.plane_x) * 50'(cam_r);
        prody_r <= 50'(cfg.plane_y) * 50'(cam_r);
      end
      ST_RAY: begin
        rx_r <= 35'(cfg.dir_x) + 35'(prodx_r >>> 16);
        ry_r <= 35'(cfg.dir_y) + 35'(prody_r >>> 16);
      end
      ST_DXW: if (drsp.done)
        dx_r <= (arx == '0) ? DELTA_SAT : DELTA_W'(drsp.quotient);
      ST_DYW: if (drsp.done)
        dy_r <= (ary == '0) ? DELTA_SAT : DELTA_W'(drsp.quotient);
      ST_SIDE: begin
        sx_r    <= (dx_r == DELTA_SAT) ? SIDE_W'(DELTA_SAT) : SIDE_W'(px_prod >> 16);
        sy_r    <= (dy_r == DELTA_SAT) ? SIDE_W'(DELTA_SAT) : SIDE_W'(py_prod >> 16);
        nx_r    <= rx_r[34];
        ny_r    <= ry_r[34];
        mx_r    <= XW'(cfg.pos_x[20:16]);
        my_r    <= XW'(cfg.pos_y[20:16]);
        steps_r <= '0;
        dist_r  <= '0;
        side_r  <= 1'b0;
        code_r  <= '0;
        esc_r   <= 1'b0;
      end
      ST_WALK: begin
        dist_r <= go_x ? sx_r : sy_r;
        side_r <= !go_x;
        if (leave) begin
          esc_r <= 1'b1;
        end else begin
          if (go_x) sx_r <= sx_r + SIDE_W'(dx_r);
          else sy_r <= sy_r + SIDE_W'(dy_r);
          mx_r <= nmx;
          my_r <= nmy;
        end
      end
      ST_TEST: begin
        code_r  <= rdata;
        steps_r <= steps_r + 1'b1;
        if (rdata == '0 && steps_r == SCW'(NSTEP)) esc_r <= 1'b1;
      end
      ST_FIN: begin
        lh_r   <= h;
        dist_r <= SIDE_W'(dsat);
        if (outside) esc_r <= 1'b1;
      end
      ST_LHW: if (drsp.done)
        lh_r <= (drsp.quotient > DIV_NW'(h)) ? h : drsp.quotient[12:0];
      ST_LINE: begin
        res_r.hit_side      <= side_r;
        res_r.hit_x         <= mx_r[4:0];
        res_r.hit_y         <= my_r[4:0];
        res_r.wall_code     <= esc_r ? 8'd0 : code_r;
        res_r.wall_distance <= dist_r[23:0];
        res_r.line_height   <= lh_r;
        res_r.line_bottom   <= bot;
        res_r.line_top      <= (top_sum > {1'b0, h}) ? ((h != '0) ? h - 1'b1 : 13'd0)
                                                     : top_sum[12:0];
        res_r.escaped       <= esc_r;
      end
      default: ;
    endcase
  end

  ddag_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  ddag_ram #(.W(8), .DEPTH(DEPTH)) u_map (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata_r(rdata)
  );
endmodule

// ===== rtl/dda_grid_ray_caster.sv =====
// Top level of the DDA grid ray caster: configuration registers and channels.
// Input requests enter through in_push/in_full. A map write (action 0) stores
// one cell, if it lies inside the map, and gives no result. A cast (action 1)
// gives one result on out_data, read with out_pop while out_empty is low.
// A cast runs three divisions on the shared divider (column to camera offset,
// then the two inverse ray components), the ray setup, a walk of up to
// 2*MAP_SIZE+3 grid steps, each a WALK and a TEST state (the map RAM read is
// registered), and, for a nonzero distance, one more division for the line
// height.
// Requests are queued two deep ahead of the back end and results two deep
// behind it; when out_pop stays low, the back end holds a finished result
// and further requests fill the input queue until in_full rises.
// After reset a clearing pass zeroes all MAP_SIZE*MAP_SIZE map cells, one cell
// a cycle, with in_full held high; configuration writes are taken at any time
// and return to their defaults at reset.
module dda_grid_ray_caster #(
  parameter int MAP_SIZE = ddag_pkg::MAP_SIZE_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_push,
  input  ddag_pkg::in_t  in_data,
  output logic           in_full,
  output logic           out_empty,
  input  logic           out_pop,
  output ddag_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_index,
  input  logic [20:0]    cfg_data
);
  import ddag_pkg::*;

  cfg_t cfg_r;
  cmd_t cmd;
  out_t res;
  logic q_full, cmd_empty, cmd_pop, res_push, res_full, clearing;

  assign in_full = q_full || clearing;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pos_x         <= POS_X_RST;
      cfg_r.pos_y         <= POS_Y_RST;
      cfg_r.dir_x         <= DIR_X_RST;
      cfg_r.dir_y         <= DIR_Y_RST;
      cfg_r.plane_x       <= PLANE_X_RST;
      cfg_r.plane_y       <= PLANE_Y_RST;
      cfg_r.screen_width  <= SCR_W_RST;
      cfg_r.screen_height <= SCR_H_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_POS_X:   cfg_r.pos_x         <= cfg_data;
        CFG_POS_Y:   cfg_r.pos_y         <= cfg_data;
        CFG_DIR_X:   cfg_r.dir_x         <= cfg_data[17:0];
        CFG_DIR_Y:   cfg_r.dir_y         <= cfg_data[17:0];
        CFG_PLANE_X: cfg_r.plane_x       <= cfg_data[17:0];
        CFG_PLANE_Y: cfg_r.plane_y       <= cfg_data[17:0];
        CFG_SCR_W:   cfg_r.screen_width  <= cfg_data[12:0];
        CFG_SCR_H:   cfg_r.screen_height <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  ddag_front #(.MAP_SIZE(MAP_SIZE)) u_front (
    .clk(clk), .rst_n(rst_n), .push(in_push && !in_full), .din(in_data),
    .full(q_full), .pop(cmd_pop), .cmd(cmd), .empty(cmd_empty)
  );

  ddag_back #(.MAP_SIZE(MAP_SIZE)) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .cmd(cmd), .cmd_empty(cmd_empty),
    .cmd_pop(cmd_pop), .res(res), .res_push(res_push), .res_full(res_full),
    .clearing(clearing)
  );

  ddag_fifo #(.W($bits(out_t)), .DEPTH(2)) u_res (
    .clk(clk), .rst_n(rst_n), .push(res_push), .din(res), .full(res_full),
    .pop(out_pop), .dout(out_data), .empty(out_empty)
  );
endmodule
